### design/msrcs_pkg.sv
// ----------------------------------------------------------------------------
// msrcs_pkg
// Shared constants and codes for the motor speed ramp command sequencer.
// ----------------------------------------------------------------------------
package msrcs_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 56;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [15:0] SPEED_ZERO = 16'd32000;

   localparam logic signed [15:0] SPEED_MIN_RST     = -16'sd5500;
   localparam logic        [15:0] SPEED_MAX_RST     = 16'd5500;
   localparam logic        [13:0] RAMP_STEP_RST     = 14'd500;
   localparam logic        [14:0] PHASE_CURRENT_RST = 15'd300;
   localparam logic        [9:0]  SEND_INTERVAL_RST = 10'd50;

   localparam logic [7:0] ANNOUNCE_BYTE  = 8'h55;
   localparam logic [7:0] HANDSHAKE_BYTE = 8'hAA;
   localparam logic [7:0] CONTROL_CMD    = 8'b0000_0011;

   localparam logic [1:0] FUNC_SPEED = 2'd0;
   localparam logic [1:0] FUNC_FRAME = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;

   localparam logic [1:0] KIND_STATUS    = 2'd0;
   localparam logic [1:0] KIND_HANDSHAKE = 2'd1;
   localparam logic [1:0] KIND_COMMAND   = 2'd2;

   localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
   localparam logic [1:0] STATUS_RANGE    = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_SPEED_MIN     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPEED_MAX     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RAMP_STEP     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_PHASE_CURRENT = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SEND_INTERVAL = 3'd4;

   typedef logic [QADDR_W-1:0] qaddr_type;
   typedef logic [QFILL_W-1:0] qfill_type;

endpackage

### design/motor_speed_ramp_command_sequencer.sv
// ----------------------------------------------------------------------------
// motor_speed_ramp_command_sequencer
// Speed request ramping, motor frame answering and send interval timing.
// ----------------------------------------------------------------------------
// One beat is handled at a time; req_tready is low until it is finished.
// A tick, an unused func or a motor frame arriving before the send interval
// is up goes back to idle after decode with no reply; a handshake or
// out-of-range request goes on to the emit state, a command frame through
// the send state to emit. An in-range speed request passes the ramp state,
// queueing at most QUEUE_DEPTH ramp steps one per cycle by a single
// add/compare unit writing the queue RAM; a stall on rsp_tready holds emit.
module motor_speed_ramp_command_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // requested_rpm[16:0], rx_first_byte[24:17], rx_middle_byte[32:25],
   // rx_last_byte[40:33], zero fill
   input  logic [msrcs_pkg::REQ_DATA_W-1:0]    req_tdata,
   // func[1:0]
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status[1:0], phase_word[17:2], speed_word[33:18], control_byte[41:34],
   // life_byte[49:42], zero fill
   output logic [msrcs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // result_kind[1:0]
   output logic [1:0]                          rsp_tuser,
   input  logic                                csr_we,
   input  logic [msrcs_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [msrcs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import msrcs_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_RAMP   = 3'd2;
   localparam logic [2:0] S_SEND   = 3'd3;
   localparam logic [2:0] S_EMIT   = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [1:0]         func_ff, func_in;
   logic signed [16:0] rpm_ff, rpm_in;
   logic [7:0]         b0_ff, b0_in, b3_ff, b3_in, b7_ff, b7_in;

   logic signed [15:0] speed_min_ff, speed_min_in;
   logic [15:0]        speed_max_ff, speed_max_in;
   logic [13:0]        ramp_step_ff, ramp_step_in;
   logic [14:0]        phase_current_ff, phase_current_in;
   logic [9:0]         send_interval_ff, send_interval_in;

   logic [15:0]        commanded_ff, commanded_in;
   logic [15:0]        aligned_ff, aligned_in;
   logic [7:0]         life_ff, life_in;
   logic [9:0]         ms_ff, ms_in;
   qaddr_type          head_ff, head_in, tail_ff, tail_in;
   qfill_type          fill_ff, fill_in;

   logic [15:0]        target_ff, target_in;
   logic [15:0]        cur_ff, cur_in;
   logic               up_ff, up_in;
   logic               from_q_ff, from_q_in;

   logic [1:0]         res_kind_ff, res_kind_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic [15:0]        res_phase_ff, res_phase_in;
   logic [15:0]        res_speed_ff, res_speed_in;
   logic [7:0]         res_ctl_ff, res_ctl_in;
   logic [7:0]         res_life_ff, res_life_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]            rsp_kind_ff, rsp_kind_in;

   logic               req_beat;
   logic               out_free;
   logic signed [17:0] rpm_x, min_x, max_x, sum_x;
   logic               out_of_range;
   logic [15:0]        target_sat;
   logic [15:0]        step_eff;
   logic [15:0]        remain;
   logic [15:0]        cur_next;
   logic               ram_we;
   logic [15:0]        ram_rd;
   logic [15:0]        send_speed;
   logic               announce;

   assign req_beat = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign rpm_x  = {rpm_ff[16], rpm_ff};
   assign min_x  = {{2{speed_min_ff[15]}}, speed_min_ff};
   assign max_x  = $signed({2'b00, speed_max_ff});
   assign sum_x  = $signed({2'b00, SPEED_ZERO}) + rpm_x;
   assign out_of_range = (rpm_x < min_x) || (rpm_x > max_x);
   assign target_sat = sum_x[17] ? 16'd0 :
                       (sum_x[16] ? 16'hFFFF : sum_x[15:0]);

   assign step_eff = (ramp_step_ff == 14'd0) ? 16'd1 : {2'b00, ramp_step_ff};
   assign remain   = up_ff ? (target_ff - cur_ff) : (cur_ff - target_ff);
   assign cur_next = up_ff ? (cur_ff + step_eff) : (cur_ff - step_eff);
   assign announce = (b0_ff == ANNOUNCE_BYTE) && (b3_ff == ANNOUNCE_BYTE) &&
                     (b7_ff == ANNOUNCE_BYTE);
   assign send_speed = from_q_ff ? ram_rd : commanded_ff;

   assign ram_we = (state_ff == S_RAMP) && (remain > step_eff) &&
                   (fill_ff != QFILL_W'(QUEUE_DEPTH));

   msrcs_ram #(
      .WIDTH (16),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (cur_next),
      .rd_addr (head_ff),
      .rd_data (ram_rd)
   );

   always_comb begin
      speed_min_in     = speed_min_ff;
      speed_max_in     = speed_max_ff;
      ramp_step_in     = ramp_step_ff;
      phase_current_in = phase_current_ff;
      send_interval_in = send_interval_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_SPEED_MIN:     speed_min_in     = $signed(csr_wdata);
            CSR_SPEED_MAX:     speed_max_in     = csr_wdata;
            CSR_RAMP_STEP:     ramp_step_in     = csr_wdata[13:0];
            CSR_PHASE_CURRENT: phase_current_in = csr_wdata[14:0];
            CSR_SEND_INTERVAL: send_interval_in = csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      rpm_in        = rpm_ff;
      b0_in         = b0_ff;
      b3_in         = b3_ff;
      b7_in         = b7_ff;
      commanded_in  = commanded_ff;
      aligned_in    = aligned_ff;
      life_in       = life_ff;
      ms_in         = ms_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      fill_in       = fill_ff;
      target_in     = target_ff;
      cur_in        = cur_ff;
      up_in         = up_ff;
      from_q_in     = from_q_ff;
      res_kind_in   = res_kind_ff;
      res_status_in = res_status_ff;
      res_phase_in  = res_phase_ff;
      res_speed_in  = res_speed_ff;
      res_ctl_in    = res_ctl_ff;
      res_life_in   = res_life_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_kind_in   = rsp_kind_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               func_in  = req_tuser;
               rpm_in   = $signed(req_tdata[16:0]);
               b0_in    = req_tdata[24:17];
               b3_in    = req_tdata[32:25];
               b7_in    = req_tdata[40:33];
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_status_in = STATUS_ACCEPTED;
            res_phase_in  = 16'd0;
            res_speed_in  = 16'd0;
            res_ctl_in    = 8'd0;
            res_life_in   = 8'd0;
            state_in      = S_IDLE;
            unique case (func_ff)
               FUNC_SPEED: begin
                  res_kind_in = KIND_STATUS;
                  if (out_of_range) begin
                     res_status_in = STATUS_RANGE;
                     state_in      = S_EMIT;
                  end else begin
                     target_in = target_sat;
                     cur_in    = commanded_ff;
                     up_in     = target_sat > commanded_ff;
                     state_in  = S_RAMP;
                  end
               end
               FUNC_FRAME: begin
                  if (announce) begin
                     res_kind_in  = KIND_HANDSHAKE;
                     res_phase_in = {HANDSHAKE_BYTE, HANDSHAKE_BYTE};
                     res_speed_in = {HANDSHAKE_BYTE, HANDSHAKE_BYTE};
                     res_ctl_in   = HANDSHAKE_BYTE;
                     res_life_in  = HANDSHAKE_BYTE;
                     life_in      = 8'd0;
                     ms_in        = 10'd0;
                     state_in     = S_EMIT;
                  end else if (ms_ff >= send_interval_ff) begin
                     from_q_in = (fill_ff != '0);
                     state_in  = S_SEND;
                  end
               end
               FUNC_TICK: begin
                  if (ms_ff < send_interval_ff) begin
                     ms_in = ms_ff + 10'd1;
                  end
               end
               default: ;
            endcase
         end
         S_RAMP: begin
            if (remain > step_eff && fill_ff != QFILL_W'(QUEUE_DEPTH)) begin
               cur_in  = cur_next;
               fill_in = fill_ff + QFILL_W'(1);
               tail_in = (tail_ff == QADDR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : tail_ff + QADDR_W'(1);
            end else begin
               res_status_in = (remain > step_eff) ? STATUS_OVERFLOW : STATUS_ACCEPTED;
               commanded_in  = target_ff;
               state_in      = S_EMIT;
            end
         end
         S_SEND: begin
            if (from_q_ff) begin
               fill_in = fill_ff - QFILL_W'(1);
               head_in = (head_ff == QADDR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : head_ff + QADDR_W'(1);
            end
            if (send_speed > SPEED_ZERO) begin
               aligned_in = SPEED_ZERO + {1'b0, phase_current_ff};
            end else if (send_speed < SPEED_ZERO) begin
               aligned_in = ({1'b0, phase_current_ff} > SPEED_ZERO) ? 16'd0
                            : SPEED_ZERO - {1'b0, phase_current_ff};
            end
            res_kind_in  = KIND_COMMAND;
            res_phase_in = aligned_in;
            res_speed_in = send_speed;
            res_ctl_in   = CONTROL_CMD;
            res_life_in  = life_ff;
            life_in      = life_ff + 8'd1;
            ms_in        = 10'd0;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_data_in  = {6'd0, res_life_ff, res_ctl_ff, res_speed_ff,
                               res_phase_ff, res_status_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         speed_min_ff     <= SPEED_MIN_RST;
         speed_max_ff     <= SPEED_MAX_RST;
         ramp_step_ff     <= RAMP_STEP_RST;
         phase_current_ff <= PHASE_CURRENT_RST;
         send_interval_ff <= SEND_INTERVAL_RST;
         commanded_ff     <= SPEED_ZERO;
         aligned_ff       <= SPEED_ZERO;
         life_ff          <= 8'd0;
         ms_ff            <= 10'd0;
         head_ff          <= '0;
         tail_ff          <= '0;
         fill_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         speed_min_ff     <= speed_min_in;
         speed_max_ff     <= speed_max_in;
         ramp_step_ff     <= ramp_step_in;
         phase_current_ff <= phase_current_in;
         send_interval_ff <= send_interval_in;
         commanded_ff     <= commanded_in;
         aligned_ff       <= aligned_in;
         life_ff          <= life_in;
         ms_ff            <= ms_in;
         head_ff          <= head_in;
         tail_ff          <= tail_in;
         fill_ff          <= fill_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      rpm_ff        <= rpm_in;
      b0_ff         <= b0_in;
      b3_ff         <= b3_in;
      b7_ff         <= b7_in;
      target_ff     <= target_in;
      cur_ff        <= cur_in;
      up_ff         <= up_in;
      from_q_ff     <= from_q_in;
      res_kind_ff   <= res_kind_in;
      res_status_ff <= res_status_in;
      res_phase_ff  <= res_phase_in;
      res_speed_ff  <= res_speed_in;
      res_ctl_ff    <= res_ctl_in;
      res_life_ff   <= res_life_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_kind_ff   <= rsp_kind_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule

### design/msrcs_ram.sv
// ----------------------------------------------------------------------------
// msrcs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module msrcs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/msrcs_checker.sv
// ----------------------------------------------------------------------------
// msrcs_checker
// Port-level checks for the motor speed ramp command sequencer.
// ----------------------------------------------------------------------------
module msrcs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [msrcs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic [1:0]                          rsp_tuser
);

   import msrcs_pkg::*;

   // a beat in means busy on the next cycle
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_STATUS |-> rsp_tdata[RSP_DATA_W-1:2] == '0)
      else $error("status beat carries frame bytes");

   a_handshake: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_HANDSHAKE |->
         rsp_tdata[49:2] == {6{HANDSHAKE_BYTE}} && rsp_tdata[1:0] == STATUS_ACCEPTED)
      else $error("bad handshake frame");

   a_command: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_COMMAND |->
         rsp_tdata[41:34] == CONTROL_CMD && rsp_tdata[1:0] == STATUS_ACCEPTED)
      else $error("bad command frame");

endmodule

bind motor_speed_ramp_command_sequencer msrcs_checker u_msrcs_checker (.*);

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the motor speed ramp command sequencer. A queue of
// beats feeds the request stream; a monitor predicts each reply from its own
// copy of the ramp queue, timer and life counter, then compares every reply
// beat in order. Registers are reprogrammed between traffic phases.
// ----------------------------------------------------------------------------
module tb_top;
   import msrcs_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 250;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_BEATS   = 104;

   localparam logic [1:0] FUNC_SPARE = 2'd3;

   typedef struct {
      logic [1:0]  func;
      logic [16:0] rpm;
      logic [7:0]  b0, b3, b7;
   } motor_beat_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [15:0] phase;
      logic [15:0] speed;
      logic [7:0]  ctl;
      logic [7:0]  life;
   } reply_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   motor_beat_type beat_backlog[$];
   reply_type      replies_due[$];

   // predicted block state and registers
   int          cfg_speed_min, cfg_speed_max, cfg_ramp_step, cfg_phase_cur, cfg_send_ivl;
   int          st_cmd_speed, st_phase, st_life, st_ms, fifo_head, fifo_fill;
   logic [15:0] ramp_fifo [QUEUE_DEPTH];

   // register values as the stimulus side sees them
   int stim_smin = -5500;
   int stim_smax = 5500;
   int stim_ivl  = 50;

   int  beats_total = 0;
   int  beats_in    = 0;
   int  phase_beats = 0;
   int  n_errors    = 0;
   int  quiet       = 0;
   int  hold_left   = 0;
   bit  hold_start  = 1'b0;
   bit  hold_done   = 1'b0;
   bit  req_fire    = 1'b0;
   wire no_gaps     = (beats_in >= 450) && (beats_in < 580);

   motor_speed_ramp_command_sequencer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   task automatic reset_model();
      cfg_speed_min = SPEED_MIN_RST;
      cfg_speed_max = SPEED_MAX_RST;
      cfg_ramp_step = RAMP_STEP_RST;
      cfg_phase_cur = PHASE_CURRENT_RST;
      cfg_send_ivl  = SEND_INTERVAL_RST;
      st_cmd_speed  = SPEED_ZERO;
      st_phase      = SPEED_ZERO;
      st_life       = 0;
      st_ms         = 0;
      fifo_head     = 0;
      fifo_fill     = 0;
   endtask

   task automatic apply_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_SPEED_MIN:     cfg_speed_min = $signed(val);
         CSR_SPEED_MAX:     cfg_speed_max = val;
         CSR_RAMP_STEP:     cfg_ramp_step = val[13:0];
         CSR_PHASE_CURRENT: cfg_phase_cur = val[14:0];
         CSR_SEND_INTERVAL: cfg_send_ivl  = val[9:0];
         default: ;
      endcase
   endtask

   task automatic predict_reply(input logic [1:0] func, input logic [16:0] rpm,
                                input logic [7:0] b0, input logic [7:0] b3, input logic [7:0] b7);
      int r, target, diff, mag, step, n, k, cur, sp;
      bit over;
      r    = $signed(rpm);
      over = 1'b0;
      case (func)
         FUNC_SPEED: begin
            if (r < cfg_speed_min || r > cfg_speed_max) begin
               replies_due.push_back({KIND_STATUS, STATUS_RANGE, 48'd0});
            end else begin
               target = int'(SPEED_ZERO) + r;
               if (target < 0) target = 0;
               if (target > 65535) target = 65535;
               diff = target - st_cmd_speed;
               mag  = (diff < 0) ? -diff : diff;
               step = (cfg_ramp_step != 0) ? cfg_ramp_step : 1;
               if (mag > step) begin
                  n   = (mag + step - 1) / step;
                  cur = st_cmd_speed;
                  for (k = 1; k < n && !over; k++) begin
                     if (fifo_fill >= QUEUE_DEPTH) begin
                        over = 1'b1;
                     end else begin
                        cur = (diff > 0) ? cur + step : cur - step;
                        ramp_fifo[(fifo_head + fifo_fill) % QUEUE_DEPTH] = cur[15:0];
                        fifo_fill++;
                     end
                  end
               end
               st_cmd_speed = target;
               replies_due.push_back({KIND_STATUS, over ? STATUS_OVERFLOW : STATUS_ACCEPTED,
                                      48'd0});
            end
         end
         FUNC_FRAME: begin
            if (b0 == ANNOUNCE_BYTE && b3 == ANNOUNCE_BYTE && b7 == ANNOUNCE_BYTE) begin
               st_life = 0;
               st_ms   = 0;
               replies_due.push_back({KIND_HANDSHAKE, STATUS_ACCEPTED,
                                      {4{HANDSHAKE_BYTE}}, HANDSHAKE_BYTE, HANDSHAKE_BYTE});
            end else if (st_ms >= cfg_send_ivl) begin
               if (fifo_fill > 0) begin
                  sp        = ramp_fifo[fifo_head];
                  fifo_head = (fifo_head + 1) % QUEUE_DEPTH;
                  fifo_fill--;
               end else begin
                  sp = st_cmd_speed;
               end
               if (sp > int'(SPEED_ZERO))
                  st_phase = int'(SPEED_ZERO) + cfg_phase_cur;
               else if (sp < int'(SPEED_ZERO))
                  st_phase = (cfg_phase_cur > int'(SPEED_ZERO)) ? 0
                             : int'(SPEED_ZERO) - cfg_phase_cur;
               replies_due.push_back({KIND_COMMAND, STATUS_ACCEPTED, st_phase[15:0], sp[15:0],
                                      CONTROL_CMD, st_life[7:0]});
               st_life = (st_life + 1) & 255;
               st_ms   = 0;
            end
         end
         FUNC_TICK: begin
            if (st_ms < cfg_send_ivl) st_ms++;
         end
         default: ;
      endcase
   endtask

   function automatic void note_mismatch(string what, reply_type want, reply_type got);
      string ws, gs;
      n_errors++;
      if (n_errors <= 10) begin
         ws = $sformatf("kind %0d status %0d phase %h speed %h ctl %h life %h",
                        want.kind, want.status, want.phase, want.speed, want.ctl, want.life);
         gs = $sformatf("kind %0d status %0d phase %h speed %h ctl %h life %h",
                        got.kind, got.status, got.phase, got.speed, got.ctl, got.life);
         $display("%0t %s: expected %s, got %s", $realtime, what, ws, gs);
      end
   endfunction

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : beat_monitor
      reply_type got;
      if (reset) begin
         reset_model();
         req_fire = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[1:0], rsp_tdata[17:2], rsp_tdata[33:18],
                   rsp_tdata[41:34], rsp_tdata[49:42]};
            if (replies_due.size() == 0)
               note_mismatch("unexpected reply", '0, got);
            else if (got !== replies_due[0])
               note_mismatch("reply mismatch", replies_due.pop_front(), got);
            else
               void'(replies_due.pop_front());
         end
         req_fire = req_tvalid && req_tready;
         if (req_fire) begin
            beats_in++;
            predict_reply(req_tuser, req_tdata[16:0], req_tdata[24:17], req_tdata[32:25],
                          req_tdata[40:33]);
         end
         if (csr_we) apply_reg(csr_addr, csr_wdata);
      end
   end

   // ---------------------------------------------------------------- driver / sink

   always @(negedge clock) begin : beat_driver
      motor_beat_type nb;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (beat_backlog.size() != 0 && (no_gaps || $urandom_range(99) >= 21)) begin
            nb = beat_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= nb.func;
            req_tdata  <= REQ_DATA_W'({nb.b7, nb.b3, nb.b0, nb.rpm});
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : reply_sink
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_start && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_gaps || ($urandom_range(99) >= 21);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic add_beat(input logic [1:0] func, input int rpm,
                           input logic [7:0] b0, input logic [7:0] b3, input logic [7:0] b7);
      motor_beat_type nb;
      nb.func = func;
      nb.rpm  = rpm[16:0];
      nb.b0   = b0;
      nb.b3   = b3;
      nb.b7   = b7;
      beat_backlog.push_back(nb);
      beats_total++;
      if (func != FUNC_SPARE) phase_beats++;
   endtask

   function automatic int rnd_rpm();
      return int'($urandom_range(131071));
   endfunction

   function automatic logic [7:0] rnd_byte();
      return 8'($urandom);
   endfunction

   task automatic add_burst();
      int pick, k, n;
      logic [7:0] x0, x3;
      pick = $urandom_range(99);
      x0   = rnd_byte();
      x3   = rnd_byte();
      if ($urandom_range(3) == 0) begin
         x0 = ANNOUNCE_BYTE;
         x3 = ANNOUNCE_BYTE;
      end
      if (pick < 40) begin
         // ticks toward the send window (enough when the interval is 6 or less), then a motor frame
         n = (stim_ivl <= 6) ? stim_ivl : $urandom_range(1, 3);
         for (k = 0; k < n; k++)
            add_beat(FUNC_TICK, rnd_rpm(), rnd_byte(), rnd_byte(), rnd_byte());
         add_beat(FUNC_FRAME, rnd_rpm(), x0, x3, rnd_byte());
      end else if (pick < 65) begin
         add_beat(FUNC_SPEED, stim_smin + int'($urandom_range(stim_smax - stim_smin)),
                  rnd_byte(), rnd_byte(), rnd_byte());
      end else if (pick < 72) begin
         add_beat(FUNC_SPEED, rnd_rpm(), rnd_byte(), rnd_byte(), rnd_byte());
      end else if (pick < 80) begin
         add_beat(FUNC_FRAME, rnd_rpm(), ANNOUNCE_BYTE, ANNOUNCE_BYTE, ANNOUNCE_BYTE);
      end else if (pick < 92) begin
         add_beat(FUNC_TICK, rnd_rpm(), rnd_byte(), rnd_byte(), rnd_byte());
      end else if (pick < 97) begin
         add_beat(FUNC_FRAME, rnd_rpm(), rnd_byte(), rnd_byte(), rnd_byte());
      end else begin
         add_beat(FUNC_SPARE, rnd_rpm(), rnd_byte(), rnd_byte(), rnd_byte());
      end
   endtask

   // called at a falling edge with the block idle
   task automatic program_regs(input int smin, input int smax, input int step,
                               input int cur, input int ivl);
      logic [CSR_ADDR_W-1:0] idx [5];
      logic [CSR_DATA_W-1:0] val [5];
      idx = '{CSR_SPEED_MIN, CSR_SPEED_MAX, CSR_RAMP_STEP, CSR_PHASE_CURRENT, CSR_SEND_INTERVAL};
      val = '{smin[15:0], smax[15:0], step[15:0], cur[15:0], ivl[15:0]};
      stim_smin = smin;
      stim_smax = smax;
      stim_ivl  = ivl;
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= idx[i];
         csr_wdata <= val[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (beats_in != beats_total || replies_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      int ph, smin, smax, step, cur, ivl;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values: range edges, ramp fill, overflow, handshake
      add_beat(FUNC_SPEED, 5500, 8'h00, 8'h00, 8'h00);
      add_beat(FUNC_SPEED, -5500, 8'hFF, 8'hFF, 8'hFF);
      add_beat(FUNC_SPEED, 5500, 8'h00, 8'h00, 8'h00);
      add_beat(FUNC_SPEED, 5501, 8'h00, 8'h00, 8'h00);
      add_beat(FUNC_SPEED, -5501, 8'h00, 8'h00, 8'h00);
      add_beat(FUNC_SPEED, -65536, 8'h00, 8'h00, 8'h00);
      add_beat(FUNC_SPEED, 65535, 8'h00, 8'h00, 8'h00);
      add_beat(FUNC_FRAME, 0, ANNOUNCE_BYTE, ANNOUNCE_BYTE, ANNOUNCE_BYTE);
      add_beat(FUNC_FRAME, 0, ANNOUNCE_BYTE, ANNOUNCE_BYTE, HANDSHAKE_BYTE);
      add_beat(FUNC_TICK, 0, 8'h00, 8'h00, 8'h00);
      add_beat(FUNC_SPARE, -1, 8'hFF, 8'hFF, 8'hFF);
      drain();

      // widest range, zero ramp step, phase current past zero offset
      program_regs(-32768, 65535, 0, 32767, 1);
      add_beat(FUNC_TICK, 0, 8'h00, 8'h00, 8'h00);
      add_beat(FUNC_FRAME, 0, 8'hFF, 8'hFF, 8'hFF);
      add_beat(FUNC_TICK, 0, 8'h00, 8'h00, 8'h00);
      add_beat(FUNC_FRAME, 0, 8'h00, 8'h00, 8'h00);
      add_beat(FUNC_SPEED, 65535, 8'h00, 8'h00, 8'h00);
      add_beat(FUNC_SPEED, -32768, 8'h00, 8'h00, 8'h00);
      add_beat(FUNC_TICK, 0, 8'h00, 8'h00, 8'h00);
      add_beat(FUNC_FRAME, 0, 8'h12, 8'h34, 8'h56);
      drain();

      program_regs(-32000, 33535, 16383, 0, 1023);
      add_beat(FUNC_SPEED, 0, 8'h00, 8'h00, 8'h00);
      add_beat(FUNC_SPEED, 33535, 8'h00, 8'h00, 8'h00);
      add_beat(FUNC_SPEED, -32000, 8'h00, 8'h00, 8'h00);
      add_beat(FUNC_FRAME, 0, ANNOUNCE_BYTE, ANNOUNCE_BYTE, ANNOUNCE_BYTE);
      add_beat(FUNC_FRAME, 0, 8'hA5, 8'h5A, 8'hC3);
      drain();

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ($urandom_range(4))
            0:       smin = -32000;
            1:       smin = 0;
            2:       smin = -32768;
            default: smin = -int'($urandom_range(32000));
         endcase
         case ($urandom_range(4))
            0:       smax = 0;
            1:       smax = 33535;
            2:       smax = 65535;
            default: smax = $urandom_range(33535);
         endcase
         case ($urandom_range(5))
            0:       step = 1;
            1:       step = 16383;
            2:       step = 0;
            default: step = $urandom_range(1, 3000);
         endcase
         case ($urandom_range(4))
            0:       cur = 0;
            1:       cur = 32000;
            2:       cur = 32767;
            default: cur = $urandom_range(32000);
         endcase
         case ($urandom_range(9))
            0:       ivl = 1023;
            1:       ivl = 1;
            2:       ivl = 50;
            default: ivl = $urandom_range(1, 6);
         endcase
         program_regs(smin, smax, step, cur, ivl);
         if (ph == 2) hold_start = 1'b1;
         phase_beats = 0;
         while (phase_beats < PHASE_BEATS)
            add_burst();
         drain();
      end

      if (replies_due.size() != 0) begin
         n_errors += replies_due.size();
         $display("%0d expected replies never arrived", replies_due.size());
      end
      if (n_errors == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

### sim.f
design/msrcs_pkg.sv
design/msrcs_ram.sv
design/motor_speed_ramp_command_sequencer.sv
design/msrcs_checker.sv
sim/tb_top.sv
